// ===== hw/rtl/sdme_pkg.sv =====
// Shared constants and types for the Slater determinant matrix element core.
package sdme_pkg;

  // Field widths fixed by the channel format
  localparam int ORB_W    = 4;
  localparam int COEF_W   = 32;
  localparam int OCC_W    = 16;
  localparam int ELEM_W   = 48;
  localparam int ACTIVE_W = 5;

  // Default orbital capacity
  localparam int NUM_ORBITALS_DEF = 16;

  // Reset value of the active orbital count register
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // Opcodes of an input beat
  localparam logic [1:0] OP_LOAD_ENERGY = 2'd0;
  localparam logic [1:0] OP_LOAD_PAIR   = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  // Outcome of one operator string applied to the ket
  typedef struct packed {
    logic hit;     // final string equals the bra
    logic negate;  // odd total fermionic sign
  } term_t;

endpackage

// ===== hw/rtl/sdme_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
interface sdme_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [sdme_pkg::ORB_W-1:0]       orbital_a;
  logic [sdme_pkg::ORB_W-1:0]       orbital_b;
  logic [sdme_pkg::ORB_W-1:0]       orbital_c;
  logic [sdme_pkg::ORB_W-1:0]       orbital_d;
  logic signed [sdme_pkg::COEF_W-1:0] coefficient;
  logic [sdme_pkg::OCC_W-1:0]       bra_occupancy;
  logic [sdme_pkg::OCC_W-1:0]       ket_occupancy;

  modport source (
    output valid, opcode, orbital_a, orbital_b, orbital_c, orbital_d,
           coefficient, bra_occupancy, ket_occupancy,
    input  ready
  );
  modport sink (
    input  valid, opcode, orbital_a, orbital_b, orbital_c, orbital_d,
           coefficient, bra_occupancy, ket_occupancy,
    output ready
  );
endinterface

interface sdme_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdme_pkg::ELEM_W-1:0] matrix_element;
  logic                               saturated;

  modport source (output valid, matrix_element, saturated, input ready);
  modport sink   (input valid, matrix_element, saturated, output ready);
endinterface

// ===== hw/rtl/sdme_coef_ram.sv =====
// Single-port interaction coefficient memory with registered read data.
module sdme_coef_ram #(
  parameter int ADDR_W = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [sdme_pkg::COEF_W-1:0]   wdata,
  output logic [sdme_pkg::COEF_W-1:0]   rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [sdme_pkg::COEF_W-1:0] mem_r [DEPTH];
  logic [sdme_pkg::COEF_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sdme_term.sv =====
// Match and fermionic sign of annihilate d, annihilate c, create b, create a on the ket.
module sdme_term #(
  parameter int NUM_ORBITALS = sdme_pkg::NUM_ORBITALS_DEF
) (
  input  logic [((NUM_ORBITALS > sdme_pkg::OCC_W) ? NUM_ORBITALS : sdme_pkg::OCC_W)-1:0] ket,
  input  logic [((NUM_ORBITALS > sdme_pkg::OCC_W) ? NUM_ORBITALS : sdme_pkg::OCC_W)-1:0] bra,
  input  logic [((NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1)-1:0]                  idx_a,
  input  logic [((NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1)-1:0]                  idx_b,
  input  logic [((NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1)-1:0]                  idx_c,
  input  logic [((NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1)-1:0]                  idx_d,
  output sdme_pkg::term_t                                                             term
);

  localparam int STR_W = (NUM_ORBITALS > sdme_pkg::OCC_W) ? NUM_ORBITALS : sdme_pkg::OCC_W;

  logic [STR_W-1:0] bit_a, bit_b, bit_c, bit_d;
  logic [STR_W-1:0] s1, s2, s3;
  logic             p1, p2, p3, p4;
  logic             ok;

  always_comb begin
    bit_a = STR_W'(1) << idx_a;
    bit_b = STR_W'(1) << idx_b;
    bit_c = STR_W'(1) << idx_c;
    bit_d = STR_W'(1) << idx_d;

    // intermediate strings after each operator
    s1 = ket & ~bit_d;
    s2 = s1 & ~bit_c;
    s3 = s2 | bit_b;

    // parity of occupied bits below each operator's index
    p1 = ^(ket & (bit_d - STR_W'(1)));
    p2 = ^(s1 & (bit_c - STR_W'(1)));
    p3 = ^(s2 & (bit_b - STR_W'(1)));
    p4 = ^(s3 & (bit_a - STR_W'(1)));

    ok = ((ket & bit_d) != '0) && ((s1 & bit_c) != '0) &&
         ((s2 & bit_b) == '0) && ((s3 & bit_a) == '0) &&
         ((s3 | bit_a) == bra);

    term.hit    = ok;
    term.negate = p1 ^ p2 ^ p3 ^ p4;
  end

endmodule

// ===== hw/rtl/slater_determinant_matrix_element_core.sv =====
// Top level: Slater determinant Hamiltonian matrix element engine.
// Usage:
//   in_chan (valid/ready) carries one beat per operation. Opcode load energy
//   writes orbital_energy[orbital_a]; opcode load coefficient writes the
//   interaction memory at (a,b,c,d); an index at or above NUM_ORBITALS drops
//   the load. Opcode compute takes bra/ket occupancy strings and yields one
//   beat on out_chan: the element (Q.18 with default fraction) and a flag set
//   when the sum was clipped to 48 bits. The fourth opcode is dropped.
//   cfg_wr_en/cfg_wr_data set the active orbital count (reset 16).
// Timing:
//   A compute walks n = min(active, NUM_ORBITALS) one-body orbitals, then
//   n^4 quadruples at one memory read per cycle, then drains the last read.
//   out_chan.valid rises once the result is registered; in_chan.ready rises
//   with it, so a new compute is accepted only after the last one finishes.
// Reset and stall:
//   After reset the interaction memory is zeroed, one entry a cycle, over all
//   2^(4*ceil(log2 NUM_ORBITALS)) entries (65536 by default); in_chan.ready is
//   low meanwhile. A result waits in the output register while out_chan.ready
//   is low; loads and a new compute are still accepted, and a finished
//   compute holds until the output register is free.
module slater_determinant_matrix_element_core #(
  parameter int NUM_ORBITALS = sdme_pkg::NUM_ORBITALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sdme_in_if.sink                           in_chan,
  sdme_out_if.source                        out_chan,
  input  logic                              cfg_wr_en,
  input  logic [sdme_pkg::ACTIVE_W-1:0]     cfg_wr_data
);

  localparam int IDX_W  = (NUM_ORBITALS > 1) ? $clog2(NUM_ORBITALS) : 1;
  localparam int ADDR_W = 4 * IDX_W;
  localparam int STR_W  = (NUM_ORBITALS > sdme_pkg::OCC_W) ? NUM_ORBITALS : sdme_pkg::OCC_W;
  localparam int ACC_W  = ADDR_W + sdme_pkg::COEF_W + 3;
  localparam int CW     = sdme_pkg::COEF_W;
  localparam int EW     = sdme_pkg::ELEM_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENERGY,
    ST_PAIR,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [sdme_pkg::ACTIVE_W-1:0]   active_r;
  logic [ADDR_W-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [STR_W-1:0]                bra_r, bra_nxt;
  logic [STR_W-1:0]                ket_r, ket_nxt;
  logic [IDX_W-1:0]                last_r, last_nxt;
  logic [IDX_W-1:0]                qa_r, qa_nxt, qb_r, qb_nxt;
  logic [IDX_W-1:0]                qc_r, qc_nxt, qd_r, qd_nxt;
  logic signed [ACC_W-1:0]         acc_r, acc_nxt;
  logic                            pend_r, pend_nxt;
  sdme_pkg::term_t                 term_r, term_nxt;
  logic signed [CW-1:0]            energy_r [NUM_ORBITALS];
  logic                            out_valid_r, out_valid_nxt;
  logic signed [EW-1:0]            elem_r, elem_nxt;
  logic                            sat_r, sat_nxt;

  logic                            in_fire;
  logic                            idx_ok_a, idx_ok_all;
  logic [5:0]                      walk_n;
  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_addr;
  logic [CW-1:0]                   ram_wdata;
  logic [CW-1:0]                   ram_rdata;
  sdme_pkg::term_t                 term_now;
  logic signed [ACC_W-1:0]         addend;
  logic signed [ACC_W-1:0]         coef_ext;
  logic                            over;
  logic                            out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Load index range checks
  assign idx_ok_a   = 32'(in_chan.orbital_a) < 32'(NUM_ORBITALS);
  assign idx_ok_all = idx_ok_a &&
                      (32'(in_chan.orbital_b) < 32'(NUM_ORBITALS)) &&
                      (32'(in_chan.orbital_c) < 32'(NUM_ORBITALS)) &&
                      (32'(in_chan.orbital_d) < 32'(NUM_ORBITALS));

  // Orbitals walked: the active count capped at capacity
  assign walk_n = (6'(active_r) > 6'(NUM_ORBITALS)) ? 6'(NUM_ORBITALS) : 6'(active_r);

  // Memory port: clearing pass, coefficient load or walk read
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = {qa_r, qb_r, qc_r, qd_r};
    case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
      end
      ST_IDLE: begin
        ram_addr  = {IDX_W'(in_chan.orbital_a), IDX_W'(in_chan.orbital_b),
                     IDX_W'(in_chan.orbital_c), IDX_W'(in_chan.orbital_d)};
        ram_wdata = in_chan.coefficient;
        ram_we    = in_fire && (in_chan.opcode == sdme_pkg::OP_LOAD_PAIR) && idx_ok_all;
      end
      default: begin
        ram_addr = {qa_r, qb_r, qc_r, qd_r};
      end
    endcase
  end

  sdme_coef_ram #(
    .ADDR_W (ADDR_W)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sdme_term #(
    .NUM_ORBITALS (NUM_ORBITALS)
  ) u_term (
    .ket   (ket_r),
    .bra   (bra_r),
    .idx_a (qa_r),
    .idx_b (qb_r),
    .idx_c (qc_r),
    .idx_d (qd_r),
    .term  (term_now)
  );

  // Accumulator addend: one-body energy (times four) or a signed coefficient
  assign coef_ext = ACC_W'($signed(ram_rdata));
  always_comb begin
    addend = '0;
    if (state_r == ST_ENERGY) begin
      if (((ket_r & (STR_W'(1) << qa_r)) != '0) && (ket_r == bra_r)) begin
        addend = ACC_W'(energy_r[qa_r]) <<< 2;
      end
    end else if (pend_r && term_r.hit) begin
      addend = term_r.negate ? -coef_ext : coef_ext;
    end
  end

  // Sum outside the 48-bit range when the high bits disagree with the sign
  assign over = (acc_r[ACC_W-1:EW-1] != '0) && (acc_r[ACC_W-1:EW-1] != '1);

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    bra_nxt       = bra_r;
    ket_nxt       = ket_r;
    last_nxt      = last_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    qc_nxt        = qc_r;
    qd_nxt        = qd_r;
    acc_nxt       = acc_r + addend;
    pend_nxt      = 1'b0;
    term_nxt      = term_now;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    elem_nxt      = elem_r;
    sat_nxt       = sat_r;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (in_chan.opcode == sdme_pkg::OP_COMPUTE)) begin
          bra_nxt  = STR_W'(in_chan.bra_occupancy);
          ket_nxt  = STR_W'(in_chan.ket_occupancy);
          last_nxt = IDX_W'(walk_n - 6'd1);
          acc_nxt  = '0;
          qa_nxt   = '0;
          qb_nxt   = '0;
          qc_nxt   = '0;
          qd_nxt   = '0;
          state_nxt = (walk_n == 6'd0) ? ST_DONE : ST_ENERGY;
        end
      end
      ST_ENERGY: begin
        // one-body walk uses qa as the orbital index
        if (qa_r == last_r) begin
          qa_nxt    = '0;
          state_nxt = ST_PAIR;
        end else begin
          qa_nxt = qa_r + 1'b1;
        end
      end
      ST_PAIR: begin
        pend_nxt = 1'b1;
        // d fastest, then c, b, a
        if (qd_r != last_r) begin
          qd_nxt = qd_r + 1'b1;
        end else begin
          qd_nxt = '0;
          if (qc_r != last_r) begin
            qc_nxt = qc_r + 1'b1;
          end else begin
            qc_nxt = '0;
            if (qb_r != last_r) begin
              qb_nxt = qb_r + 1'b1;
            end else begin
              qb_nxt = '0;
              if (qa_r != last_r) begin
                qa_nxt = qa_r + 1'b1;
              end else begin
                qa_nxt    = '0;
                state_nxt = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        // last read data lands in the accumulator
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          sat_nxt       = over;
          if (over) begin
            elem_nxt = acc_r[ACC_W-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
          end else begin
            elem_nxt = acc_r[EW-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      qa_r        <= '0;
      qb_r        <= '0;
      qc_r        <= '0;
      qd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      qa_r        <= qa_nxt;
      qb_r        <= qb_nxt;
      qc_r        <= qc_nxt;
      qd_r        <= qd_nxt;
    end
    bra_r  <= bra_nxt;
    ket_r  <= ket_nxt;
    last_r <= last_nxt;
    acc_r  <= acc_nxt;
    term_r <= term_nxt;
    elem_r <= elem_nxt;
    sat_r  <= sat_nxt;
  end

  // Active orbital count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= sdme_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  // Orbital energy registers, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ORBITALS; i++) begin
        energy_r[i] <= '0;
      end
    end else if (in_fire && (in_chan.opcode == sdme_pkg::OP_LOAD_ENERGY) && idx_ok_a) begin
      energy_r[IDX_W'(in_chan.orbital_a)] <= in_chan.coefficient;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.matrix_element = elem_r;
  assign out_chan.saturated      = sat_r;

endmodule
